/* rtl/core/ktr_pkg.sv */
// ----------------------------------------------------------------------------
// ktr_pkg
// Shared types and codes of the keyed task ring.
// ----------------------------------------------------------------------------
package ktr_pkg;

  localparam logic [1:0] ACT_ENQUEUE   = 2'd0;
  localparam logic [1:0] ACT_CLAIM     = 2'd1;
  localparam logic [1:0] ACT_PUBLISH   = 2'd2;
  localparam logic [1:0] ACT_UNPUBLISH = 2'd3;

  localparam int MASK_W = 32;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] scan;
    logic [31:0] gen;
    logic [31:0] low_blk;
    logic [31:0] high_blk;
  } task_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] pid;
  } worker_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic vwr_en;
    logic vwr_bit;
  } ring_op_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic set_en;
    logic clr_en;
  } worker_op_t;

endpackage

/* rtl/core/ktr_ring_store.sv */
// ----------------------------------------------------------------------------
// ktr_ring_store
// Task entry memory and valid bit memory, one registered read port.
// ----------------------------------------------------------------------------
module ktr_ring_store import ktr_pkg::*; #(
  parameter int RING_DEPTH = 256,
  parameter int RA         = $clog2(RING_DEPTH)
) (
  input  logic          clk,
  input  ring_op_t      op,
  input  logic [RA-1:0] rd_addr,
  input  logic [RA-1:0] wr_addr,
  input  task_t         wr_data,
  input  logic [RA-1:0] vwr_addr,
  output task_t         rd_data,
  output logic          rd_valid
);

  task_t mem [RING_DEPTH];
  logic  vmem [RING_DEPTH];

  // Entries are read only between head and tail, so neither memory needs clearing.
  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (op.vwr_en) begin
      vmem[vwr_addr] <= op.vwr_bit;
    end
    if (op.rd_en) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= vmem[rd_addr];
    end
  end

endmodule

/* rtl/core/ktr_worker_store.sv */
// ----------------------------------------------------------------------------
// ktr_worker_store
// Worker registry: key and process id memory plus per-slot used flags.
// ----------------------------------------------------------------------------
module ktr_worker_store import ktr_pkg::*; #(
  parameter int WORKER_SLOTS = 32,
  parameter int WA           = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  worker_op_t              op,
  input  logic [WA-1:0]           rd_addr,
  input  logic [WA-1:0]           wr_addr,
  input  worker_t                 wr_data,
  input  logic [WA-1:0]           clr_addr,
  output worker_t                 rd_data,
  output logic [WORKER_SLOTS-1:0] used
);

  worker_t mem [WORKER_SLOTS];

  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (op.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (op.clr_en) begin
        used[clr_addr] <= 1'b0;
      end
      if (op.set_en) begin
        used[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/keyed_task_ring_with_worker_wake.sv */
// ----------------------------------------------------------------------------
// keyed_task_ring_with_worker_wake
// Keyed task ring with a worker registry that reports which workers to wake.
// ----------------------------------------------------------------------------
// One word is taken at a time: the input channel stalls from acceptance until
// the result word has been loaded into the output register, which then holds
// it while the next word is worked on. Every access goes through the single
// read port of a memory, one entry per cycle, so the cost of a word is set by
// how many entries it walks. Enqueue writes the entry at tail if the ring is
// not full, then the wake scan reads each of the first min(WORKER_SLOTS, 32)
// registry slots. Claim walks from head to the match or to tail, then rewinds
// and moves head past the invalid entries it finds. Publish and unpublish
// read every registry slot. There is no clearing pass after reset: only
// entries between head and tail are ever read, and each was written by an
// enqueue. Output fields that the action does not produce are zero. Wake
// mask bits exist only for the first 32 registry slots.
// ----------------------------------------------------------------------------
module keyed_task_ring_with_worker_wake import ktr_pkg::*; #(
  parameter int RING_DEPTH   = 256,
  parameter int WORKER_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] db_key,
  input  logic [31:0] scan_number,
  input  logic [31:0] generation_in,
  input  logic [31:0] low_block_in,
  input  logic [31:0] high_block_in,
  input  logic [31:0] worker_pid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        enqueue_accepted,
  output logic        claim_found,
  output logic [31:0] out_scan_number,
  output logic [31:0] out_generation,
  output logic [31:0] out_low_block,
  output logic [31:0] out_high_block,
  output logic [31:0] wake_mask,
  output logic        registered
);

  localparam int RA     = $clog2(RING_DEPTH);
  localparam int CW     = $clog2(2 * RING_DEPTH);
  localparam int WA     = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
  localparam int WC     = $clog2(WORKER_SLOTS + 1);
  localparam int WAKE_N = (WORKER_SLOTS < MASK_W) ? WORKER_SLOTS : MASK_W;

  localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
  localparam logic [CW-1:0] LAST_C   = CW'(2 * RING_DEPTH - 1);
  localparam logic [CW:0]   TWO_D    = (CW + 1)'(2 * RING_DEPTH);
  localparam logic [WC-1:0] SLOTS_C  = WC'(WORKER_SLOTS);
  localparam logic [WC-1:0] WAKE_C   = WC'(WAKE_N);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ENQ   = 3'd1;
  localparam logic [2:0] ST_WAKE  = 3'd2;
  localparam logic [2:0] ST_CLAIM = 3'd3;
  localparam logic [2:0] ST_HEAD  = 3'd4;
  localparam logic [2:0] ST_PUB   = 3'd5;
  localparam logic [2:0] ST_UNPUB = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  function automatic logic [RA-1:0] slot_of(input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = (c >= DEPTH_C) ? (c - DEPTH_C) : c;
    return s[RA-1:0];
  endfunction

  function automatic logic [CW-1:0] count_next(input logic [CW-1:0] c);
    return (c == LAST_C) ? '0 : c + 1'b1;
  endfunction

  logic [2:0]  state;
  logic [31:0] key;
  logic [31:0] pid;
  task_t       item;

  logic [CW-1:0] head;
  logic [CW-1:0] tail;
  logic [CW-1:0] ring_iss;
  logic          ring_pend;
  logic [CW-1:0] ring_pcnt;

  logic [WC-1:0] wk_iss;
  logic          wk_pend;
  logic [WA-1:0] wk_pidx;

  logic          have_match;
  logic [WA-1:0] match_idx;
  logic          have_free;
  logic [WA-1:0] free_slot;

  // result being built for the current word
  logic        res_enq;
  logic        res_found;
  task_t       res_task;
  logic [31:0] res_mask;
  logic        res_reg;

  ring_op_t    ring_op;
  task_t       ring_rd;
  logic        ring_rd_valid;
  logic [RA-1:0] ring_vwr_addr;

  worker_op_t  wk_op;
  worker_t     wk_rd;
  logic [WORKER_SLOTS-1:0] wk_used;
  logic [WA-1:0] wk_wr_addr;

  logic [CW:0] occ_wrap;
  logic [CW:0] occ;
  logic        full;
  logic        ring_hit;
  logic        wk_key_hit;
  logic        wk_pid_hit;
  logic        out_free;
  logic        ring_more;
  logic        wk_more;
  logic        claim_end;

  // hold off input during reset and while a word is being worked on
  assign in_stall  = rst || (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign occ_wrap  = {1'b0, tail} + TWO_D - {1'b0, head};
  assign occ       = (tail >= head) ? {1'b0, tail - head} : occ_wrap;
  assign full      = (occ == {1'b0, DEPTH_C});

  assign ring_more = (ring_iss != tail);
  assign wk_more   = (state == ST_WAKE) ? (wk_iss < WAKE_C) : (wk_iss < SLOTS_C);

  assign ring_hit   = ring_pend && ring_rd_valid && (ring_rd.key == key);
  assign wk_key_hit = wk_used[wk_pidx] && (wk_rd.key == key);
  assign wk_pid_hit = wk_used[wk_pidx] && (wk_rd.pid == pid);

  // claim walk ends on a hit or once the last pending read came back empty
  assign claim_end  = (state == ST_CLAIM) && (ring_hit || (!ring_pend && !ring_more));

  // Memory controls: walk one entry per cycle, write on enqueue or claim hit.
  always_comb begin
    ring_op.rd_en   = ((state == ST_CLAIM) || (state == ST_HEAD)) && ring_more;
    ring_op.wr_en   = (state == ST_ENQ) && !full;
    ring_op.vwr_en  = ((state == ST_ENQ) && !full) || ((state == ST_CLAIM) && ring_hit);
    ring_op.vwr_bit = (state == ST_ENQ);
    ring_vwr_addr   = (state == ST_ENQ) ? slot_of(tail) : slot_of(ring_pcnt);

    wk_op.rd_en  = ((state == ST_WAKE) || (state == ST_PUB) || (state == ST_UNPUB)) &&
                   wk_more;
    wk_op.wr_en  = (state == ST_PUB) && !wk_pend && !wk_more && (have_match || have_free);
    wk_op.set_en = wk_op.wr_en;
    wk_op.clr_en = (state == ST_UNPUB) && wk_pend && wk_pid_hit;
    wk_wr_addr   = have_match ? match_idx : free_slot;
  end

  ktr_ring_store #(
    .RING_DEPTH (RING_DEPTH),
    .RA         (RA)
  ) u_ring (
    .clk      (clk),
    .op       (ring_op),
    .rd_addr  (slot_of(ring_iss)),
    .wr_addr  (slot_of(tail)),
    .wr_data  (item),
    .vwr_addr (ring_vwr_addr),
    .rd_data  (ring_rd),
    .rd_valid (ring_rd_valid)
  );

  ktr_worker_store #(
    .WORKER_SLOTS (WORKER_SLOTS),
    .WA           (WA)
  ) u_workers (
    .clk      (clk),
    .rst      (rst),
    .op       (wk_op),
    .rd_addr  (wk_iss[WA-1:0]),
    .wr_addr  (wk_wr_addr),
    .wr_data  ({key, pid}),
    .clr_addr (wk_pidx),
    .rd_data  (wk_rd),
    .used     (wk_used)
  );

  // Payload capture and result building.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          key           <= db_key;
          pid           <= worker_pid;
          item.key      <= db_key;
          item.scan     <= scan_number;
          item.gen      <= generation_in;
          item.low_blk  <= low_block_in;
          item.high_blk <= high_block_in;
          res_enq       <= 1'b0;
          res_found     <= 1'b0;
          res_task      <= '0;
          res_mask      <= '0;
          res_reg       <= 1'b0;
        end
      end
      ST_ENQ: begin
        if (!full) begin
          res_enq <= 1'b1;
        end
      end
      ST_WAKE: begin
        if (wk_pend && wk_key_hit) begin
          res_mask <= res_mask | (32'(1) << wk_pidx);
        end
      end
      ST_CLAIM: begin
        if (ring_hit) begin
          res_found         <= 1'b1;
          res_task.scan     <= ring_rd.scan;
          res_task.gen      <= ring_rd.gen;
          res_task.low_blk  <= ring_rd.low_blk;
          res_task.high_blk <= ring_rd.high_blk;
        end
      end
      ST_PUB: begin
        if (wk_op.wr_en) begin
          res_reg <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: one word at a time, memories walked one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      ring_iss   <= '0;
      ring_pend  <= 1'b0;
      ring_pcnt  <= '0;
      wk_iss     <= '0;
      wk_pend    <= 1'b0;
      wk_pidx    <= '0;
      have_match <= 1'b0;
      match_idx  <= '0;
      have_free  <= 1'b0;
      free_slot  <= '0;
    end else begin
      // issue side: advance the read pointers and track the pending read;
      // at the end of the claim walk rewind to head for the skip pass
      if (claim_end) begin
        ring_iss  <= head;
        ring_pend <= 1'b0;
      end else begin
        ring_pend <= ring_op.rd_en;
        if (ring_op.rd_en) begin
          ring_pcnt <= ring_iss;
          ring_iss  <= count_next(ring_iss);
        end
      end
      wk_pend <= wk_op.rd_en;
      if (wk_op.rd_en) begin
        wk_pidx <= wk_iss[WA-1:0];
        wk_iss  <= wk_iss + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ring_iss   <= head;
            wk_iss     <= '0;
            have_match <= 1'b0;
            have_free  <= 1'b0;
            case (action)
              ACT_ENQUEUE:   state <= ST_ENQ;
              ACT_CLAIM:     state <= ST_CLAIM;
              ACT_PUBLISH:   state <= ST_PUB;
              ACT_UNPUBLISH: state <= ST_UNPUB;
              default:       state <= ST_DONE;
            endcase
          end
        end
        ST_ENQ: begin
          // full ring: drop the word and report zeros
          if (full) begin
            state <= ST_DONE;
          end else begin
            tail  <= count_next(tail);
            state <= ST_WAKE;
          end
        end
        ST_WAKE: begin
          if (!wk_pend && !wk_more) begin
            state <= ST_DONE;
          end
        end
        ST_CLAIM: begin
          if (claim_end) begin
            state <= ST_HEAD;
          end
        end
        ST_HEAD: begin
          if (ring_pend) begin
            if (ring_rd_valid) begin
              state <= ST_DONE;
            end else begin
              head <= count_next(ring_pcnt);
            end
          end else if (!ring_more) begin
            state <= ST_DONE;
          end
        end
        ST_PUB: begin
          if (wk_pend) begin
            if (wk_pid_hit && !have_match) begin
              have_match <= 1'b1;
              match_idx  <= wk_pidx;
            end
            if (!wk_used[wk_pidx] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= wk_pidx;
            end
          end else if (!wk_more) begin
            state <= ST_DONE;
          end
        end
        ST_UNPUB: begin
          if (!wk_pend && !wk_more) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load when the result is complete and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      enqueue_accepted <= res_enq;
      claim_found      <= res_found;
      out_scan_number  <= res_task.scan;
      out_generation   <= res_task.gen;
      out_low_block    <= res_task.low_blk;
      out_high_block   <= res_task.high_blk;
      wake_mask        <= res_mask;
      registered       <= res_reg;
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed task ring with worker wake.
// A queue of pending words feeds a clocked driver with random gaps; a clocked
// monitor with random stalls checks every result word against a behavioral
// copy of the ring and the worker registry, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ktr_pkg::*;

  localparam int RING_DEPTH   = 256;
  localparam int WORKER_SLOTS = 32;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] db_key;
    logic [31:0] scan;
    logic [31:0] gen;
    logic [31:0] low_blk;
    logic [31:0] high_blk;
    logic [31:0] pid;
  } request_t;

  typedef struct packed {
    logic        accepted;
    logic        found;
    logic [31:0] scan;
    logic [31:0] gen;
    logic [31:0] low_blk;
    logic [31:0] high_blk;
    logic [31:0] wake;
    logic        registered;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0]  action = ACT_ENQUEUE;
  logic [31:0] db_key = '0, scan_number = '0, generation_in = '0;
  logic [31:0] low_block_in = '0, high_block_in = '0, worker_pid = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic enqueue_accepted, claim_found, registered;
  logic [31:0] out_scan_number, out_generation, out_low_block, out_high_block;
  logic [31:0] wake_mask;

  keyed_task_ring_with_worker_wake #(
    .RING_DEPTH(RING_DEPTH), .WORKER_SLOTS(WORKER_SLOTS)
  ) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block state.
  logic        ring_valid [RING_DEPTH];
  task_t       ring_entry [RING_DEPTH];
  int unsigned head_cnt, tail_cnt;
  logic        slot_used [WORKER_SLOTS];
  worker_t     slot_entry [WORKER_SLOTS];

  request_t pending_words[$];
  reply_t   expected_replies[$];
  int       mismatch_count = 0;
  int       reply_count = 0;
  bit       stimulus_done = 1'b0;

  // Pressure controls: long receiver hold-off, and sender drain pause.
  int       hold_cycles = 0;
  bit       drain_req = 1'b0;

  function automatic int unsigned ring_fill();
    return (tail_cnt + 2 * RING_DEPTH - head_cnt) % (2 * RING_DEPTH);
  endfunction

  function automatic int unsigned bump(int unsigned c);
    return (c + 1 >= 2 * RING_DEPTH) ? 0 : c + 1;
  endfunction

  // Advance the shadow state by one word and return its reply.
  function automatic reply_t predict_reply(request_t r);
    reply_t      y;
    int unsigned c, s;
    int          pick;
    y = '0;
    case (r.action)
      ACT_ENQUEUE: begin
        if (ring_fill() < RING_DEPTH) begin
          s = tail_cnt % RING_DEPTH;
          ring_valid[s] = 1'b1;
          ring_entry[s] = '{r.db_key, r.scan, r.gen, r.low_blk, r.high_blk};
          tail_cnt = bump(tail_cnt);
          for (int i = 0; i < WORKER_SLOTS && i < 32; i++)
            if (slot_used[i] && slot_entry[i].key == r.db_key) y.wake[i] = 1'b1;
          y.accepted = 1'b1;
        end
      end
      ACT_CLAIM: begin
        c = head_cnt;
        while (c != tail_cnt) begin
          s = c % RING_DEPTH;
          if (ring_valid[s] && ring_entry[s].key == r.db_key) begin
            y.found    = 1'b1;
            y.scan     = ring_entry[s].scan;
            y.gen      = ring_entry[s].gen;
            y.low_blk  = ring_entry[s].low_blk;
            y.high_blk = ring_entry[s].high_blk;
            ring_valid[s] = 1'b0;
            break;
          end
          c = bump(c);
        end
        while (head_cnt != tail_cnt && !ring_valid[head_cnt % RING_DEPTH])
          head_cnt = bump(head_cnt);
      end
      ACT_PUBLISH: begin
        pick = -1;
        for (int i = 0; i < WORKER_SLOTS; i++) begin
          if (slot_used[i] && slot_entry[i].pid == r.pid) begin
            pick = i;
            break;
          end
          if (pick < 0 && !slot_used[i]) pick = i;
        end
        if (pick >= 0) begin
          slot_used[pick]  = 1'b1;
          slot_entry[pick] = '{r.db_key, r.pid};
          y.registered = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < WORKER_SLOTS; i++)
          if (slot_used[i] && slot_entry[i].pid == r.pid) slot_used[i] = 1'b0;
      end
    endcase
    return y;
  endfunction

  function automatic request_t make_word(logic [1:0] a, logic [31:0] k,
                                         logic [31:0] p);
    request_t r;
    r = '{a, k, $urandom, $urandom, $urandom, $urandom, p};
    return r;
  endfunction

  // Keys and pids come from small pools so that claims and wakes hit.
  function automatic logic [31:0] pool_key();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      default: return 32'hA5A5_0000 + $urandom_range(0, 5);
    endcase
  endfunction

  function automatic logic [31:0] pool_pid();
    return ($urandom_range(0, 15) == 0) ? $urandom : 32'd100 + $urandom_range(0, 39);
  endfunction

  // Driver: hold the word until accepted, then draw a gap before the next.
  int  send_gap = 0;
  bit  gap_drawn = 1'b0;
  int  words_sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        words_sent++;
        expected_replies.push_back(predict_reply(pending_words.pop_front()));
        send_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (drain_req && expected_replies.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_valid      <= 1'b1;
        action        <= pending_words[0].action;
        db_key        <= pending_words[0].db_key;
        scan_number   <= pending_words[0].scan;
        generation_in <= pending_words[0].gen;
        low_block_in  <= pending_words[0].low_blk;
        high_block_in <= pending_words[0].high_blk;
        worker_pid    <= pending_words[0].pid;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted reply with the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    reply_t got, want;
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{enqueue_accepted, claim_found, out_scan_number, out_generation,
                out_low_block, out_high_block, wake_mask, registered};
        reply_count++;
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected reply word %p", got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("reply %0d mismatch: expected %p actual %p", reply_count, want, got);
          end
        end
        stall_left = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) stall_left = 0;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_cycles > 0)
      idle_cycles = 0;
    else if (!rst && !stimulus_done)
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] k;
    int          n;
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_valid[i] = 1'b0;
      ring_entry[i] = '0;
    end
    for (int i = 0; i < WORKER_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_entry[i] = '0;
    end
    head_cnt = 0;
    tail_cnt = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty claim, unknown unpublish, extreme values, reuse of a pid.
    pending_words.push_back(make_word(ACT_CLAIM, 32'h0, 32'h0));
    pending_words.push_back(make_word(ACT_UNPUBLISH, 32'h0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(ACT_PUBLISH, 32'h0, 32'h0));
    pending_words.push_back(make_word(ACT_PUBLISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_words.push_back('{ACT_ENQUEUE, 32'h0, '0, '0, '0, '0, '0});
    pending_words.push_back('{ACT_ENQUEUE, 32'hFFFF_FFFF, '1, '1, '1, '1, '1});
    pending_words.push_back(make_word(ACT_PUBLISH, 32'hFFFF_FFFF, 32'h0));
    pending_words.push_back(make_word(ACT_ENQUEUE, 32'hFFFF_FFFF, 32'h0));
    pending_words.push_back(make_word(ACT_CLAIM, 32'h1234, 32'h0));
    pending_words.push_back(make_word(ACT_CLAIM, 32'hFFFF_FFFF, 32'h0));
    pending_words.push_back(make_word(ACT_CLAIM, 32'h0, 32'h0));
    pending_words.push_back(make_word(ACT_CLAIM, 32'hFFFF_FFFF, 32'h0));
    pending_words.push_back(make_word(ACT_UNPUBLISH, 32'h5, 32'h0));
    pending_words.push_back(make_word(ACT_UNPUBLISH, 32'h5, 32'hFFFF_FFFF));

    // Fill every worker slot, then one more publish finds no slot.
    for (int i = 0; i < WORKER_SLOTS; i++)
      pending_words.push_back(make_word(ACT_PUBLISH, 32'hA5A5_0000 + i % 6, 32'd100 + i));
    pending_words.push_back(make_word(ACT_PUBLISH, 32'h7, 32'd9999));

    // Overfill the ring while the receiver holds off: the block must stall input.
    hold_cycles = 400;
    for (int i = 0; i < RING_DEPTH + 4; i++)
      pending_words.push_back(make_word(ACT_ENQUEUE, pool_key(), 32'h0));
    wait (pending_words.size() == 0);
    drain_req = 1'b1;
    wait (expected_replies.size() == 0);
    drain_req = 1'b0;

    // Random: mostly enqueue and claim on pooled keys, some registry churn.
    n = 0;
    while (n < 1500) begin
      k = pool_key();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pending_words.push_back(make_word(ACT_ENQUEUE, k, pool_pid()));
        4, 5, 6, 7: pending_words.push_back(make_word(ACT_CLAIM, k, pool_pid()));
        8:          pending_words.push_back(make_word(ACT_PUBLISH, k, pool_pid()));
        default:    pending_words.push_back(make_word(ACT_UNPUBLISH, $urandom, pool_pid()));
      endcase
      n++;
      if (n == 750) begin
        wait (pending_words.size() == 0);
        drain_req = 1'b1;
        wait (expected_replies.size() == 0);
        drain_req = 1'b0;
        hold_cycles = 300;
      end
      if (pending_words.size() > 40) wait (pending_words.size() < 10);
    end

    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_replies.size() == 0);
    stimulus_done = 1'b1;
    repeat (600) @(posedge clk);
    $display("covered %0d words: enqueue to full ring, claims, publish/unpublish churn",
             words_sent);
    $display("checked %0d replies, %0d mismatches", reply_count, mismatch_count);
    if (mismatch_count == 0 && expected_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
